// ===== rtl/dttfp_pkg.sv =====
// Package for the decimal text to fixed-point converter.
// Holds the format constants, character codes, state and command types
// and the power-of-ten table. Has no dependencies.
`default_nettype none

package dttfp_pkg;

  localparam int IntBits       = 32;
  localparam int FracBits      = 16;
  localparam int MaxFracDigits = 9;
  localparam int OutBits       = IntBits + FracBits;

  // The integer magnitude never exceeds 2^(IntBits-1)-1.
  localparam int IntAccW  = IntBits - 1;
  localparam int FracDigW = 30;
  localparam int FracCntW = 4;
  localparam int StepCntW = $clog2(FracBits);

  localparam logic [IntAccW-1:0] IntLimit = {IntAccW{1'b1}};
  localparam logic [OutBits-1:0] MagMax   = {1'b0, {(OutBits - 1){1'b1}}};

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharPoint = 8'h2E;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] CharVt    = 8'h0B;
  localparam logic [7:0] CharFf    = 8'h0C;
  localparam logic [7:0] CharCr    = 8'h0D;

  typedef enum logic [1:0] {
    PH_SPACE,
    PH_INT,
    PH_FRAC,
    PH_STOP
  } phase_e;

  typedef enum logic [1:0] {
    ST_PARSE,
    ST_PREP,
    ST_SCALE,
    ST_LOAD
  } ctrl_state_e;

  typedef struct packed {
    logic take_char;
    logic prep;
    logic div_step;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_last;
  } dp_status_t;

  function automatic logic [FracDigW-1:0] pow_ten(input logic [FracCntW-1:0] n);
    logic [FracDigW-1:0] p;
    case (n)
      4'd0:    p = 30'd1;
      4'd1:    p = 30'd10;
      4'd2:    p = 30'd100;
      4'd3:    p = 30'd1000;
      4'd4:    p = 30'd10000;
      4'd5:    p = 30'd100000;
      4'd6:    p = 30'd1000000;
      4'd7:    p = 30'd10000000;
      4'd8:    p = 30'd100000000;
      4'd9:    p = 30'd1000000000;
      default: p = 30'd1;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/dttfp_if.sv =====
// Valid/ready channel interfaces for the converter's input and output items.
// The output interface depends on dttfp_pkg for the output width.
`default_nettype none

interface dttfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_text;

  modport source (output valid, output char_code, output end_of_text, input ready);
  modport sink (input valid, input char_code, input end_of_text, output ready);
endinterface

interface dttfp_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [dttfp_pkg::OutBits-1:0] value;
  logic                                overflow;

  modport source (output valid, output value, output overflow, input ready);
  modport sink (input valid, input value, input overflow, output ready);
endinterface

`default_nettype wire

// ===== rtl/dttfp_ctrl.sv =====
// Controller of the converter: sequences parsing, fraction scaling and
// the output load, and owns both handshakes. Depends on dttfp_pkg.
`default_nettype none

module dttfp_ctrl (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        in_valid_i,
  input  wire                        in_last_i,
  output logic                       in_ready_o,
  output logic                       out_valid_o,
  input  wire                        out_ready_i,
  output dttfp_pkg::dp_cmd_t         cmd_o,
  input  wire dttfp_pkg::dp_status_t status_i
);
  import dttfp_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_PARSE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_PARSE: begin
        in_ready_o      = 1'b1;
        cmd_o.take_char = in_valid_i;
        if (in_valid_i && in_last_i) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = status_i.need_div ? ST_SCALE : ST_LOAD;
      end
      ST_SCALE: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_PARSE;
        end
      end
      default: state_d = ST_PARSE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  a_last_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_last_i |=> !in_ready_o)
    else $error("Input accepted right after the last character of a number.");

  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q)
    else $error("Output item dropped before it was accepted.");

  a_ready_in_parse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == ST_PARSE)
    else $error("Input ready outside the parse state.");

endmodule

`default_nettype wire

// ===== rtl/dttfp_dp.sv =====
// Datapath of the converter: character classifier, integer and fraction
// accumulators, a bit-serial fraction divider and the output register.
// Depends on dttfp_pkg.
`default_nettype none

module dttfp_dp (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire  [7:0]                          char_code_i,
  input  wire dttfp_pkg::dp_cmd_t             cmd_i,
  output dttfp_pkg::dp_status_t               status_o,
  output logic signed [dttfp_pkg::OutBits-1:0] value_o,
  output logic                                overflow_o
);
  import dttfp_pkg::*;

  phase_e                phase_q, phase_d;
  logic                  neg_q, neg_d;
  logic                  sat_q, sat_d;
  logic [IntAccW-1:0]    acc_q, acc_d;
  logic [FracDigW-1:0]   fd_q, fd_d;
  logic [FracCntW-1:0]   fcnt_q, fcnt_d;

  logic [FracDigW-1:0]   rem_q, rem_d;
  logic [FracBits-1:0]   quot_q, quot_d;
  logic [StepCntW-1:0]   step_q, step_d;

  logic [OutBits-1:0]    value_q, value_d;
  logic                  ovf_q;

  logic                  is_space, is_digit, is_sign;
  logic [3:0]            digit;
  logic                  do_int, do_frac;
  logic [IntAccW+3:0]    int_prod;
  logic [FracDigW+3:0]   frac_prod;
  logic [FracDigW-1:0]   divisor;
  logic [FracDigW:0]     rem_shift;
  logic                  rem_ge;
  logic [OutBits-1:0]    mag;

  assign is_space = char_code_i inside {CharSpace, CharTab, CharLf, CharVt, CharFf, CharCr};
  assign is_digit = char_code_i inside {[CharZero:CharNine]};
  assign is_sign  = (char_code_i == CharMinus) || (char_code_i == CharPlus);
  assign digit    = char_code_i[3:0];

  assign int_prod  = ({4'd0, acc_q} << 3) + ({4'd0, acc_q} << 1) + (IntAccW + 4)'(digit);
  assign frac_prod = ({4'd0, fd_q} << 3) + ({4'd0, fd_q} << 1) + (FracDigW + 4)'(digit);

  always_comb begin
    phase_d = phase_q;
    neg_d   = neg_q;
    sat_d   = sat_q;
    acc_d   = acc_q;
    fd_d    = fd_q;
    fcnt_d  = fcnt_q;
    do_int  = 1'b0;
    do_frac = 1'b0;
    if (cmd_i.take_char) begin
      case (phase_q)
        PH_SPACE: begin
          if (is_space) begin
            phase_d = PH_SPACE;
          end else if (is_sign) begin
            neg_d   = (char_code_i == CharMinus);
            phase_d = PH_INT;
          end else if (is_digit) begin
            do_int  = 1'b1;
            phase_d = PH_INT;
          end else if (char_code_i == CharPoint) begin
            phase_d = PH_FRAC;
          end else begin
            phase_d = PH_STOP;
          end
        end
        PH_INT: begin
          if (is_digit) begin
            do_int = 1'b1;
          end else if (char_code_i == CharPoint) begin
            phase_d = PH_FRAC;
          end else begin
            phase_d = PH_STOP;
          end
        end
        PH_FRAC: begin
          if (is_digit) begin
            do_frac = 1'b1;
          end else begin
            phase_d = PH_STOP;
          end
        end
        default: phase_d = PH_STOP;
      endcase
    end
    if (do_int && !sat_q) begin
      if (int_prod > (IntAccW + 4)'(IntLimit)) begin
        acc_d = IntLimit;
        sat_d = 1'b1;
      end else begin
        acc_d = int_prod[IntAccW-1:0];
      end
    end
    if (do_frac && (fcnt_q < FracCntW'(MaxFracDigits))) begin
      fd_d   = frac_prod[FracDigW-1:0];
      fcnt_d = fcnt_q + 1'b1;
    end
    if (cmd_i.load_out) begin
      phase_d = PH_SPACE;
      neg_d   = 1'b0;
      sat_d   = 1'b0;
      acc_d   = '0;
      fd_d    = '0;
      fcnt_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SPACE;
      neg_q   <= 1'b0;
      sat_q   <= 1'b0;
      acc_q   <= '0;
      fd_q    <= '0;
      fcnt_q  <= '0;
    end else begin
      phase_q <= phase_d;
      neg_q   <= neg_d;
      sat_q   <= sat_d;
      acc_q   <= acc_d;
      fd_q    <= fd_d;
      fcnt_q  <= fcnt_d;
    end
  end

  // Restoring division of the fraction digits, shifted left by FracBits,
  // by the matching power of ten: one quotient bit per cycle.
  assign divisor   = pow_ten(fcnt_q);
  assign rem_shift = {rem_q, 1'b0};
  assign rem_ge    = rem_shift >= {1'b0, divisor};

  always_comb begin
    rem_d  = rem_q;
    quot_d = quot_q;
    step_d = step_q;
    if (cmd_i.prep) begin
      rem_d  = fd_q;
      quot_d = '0;
      step_d = StepCntW'(FracBits - 1);
    end else if (cmd_i.div_step) begin
      if (rem_ge) begin
        rem_d = FracDigW'(rem_shift - {1'b0, divisor});
      end else begin
        rem_d = rem_shift[FracDigW-1:0];
      end
      quot_d = {quot_q[FracBits-2:0], rem_ge};
      step_d = step_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    step_q <= step_d;
  end

  assign status_o.need_div = (fcnt_q != '0) && !sat_q;
  assign status_o.div_last = (step_q == '0);

  always_comb begin
    if (sat_q) begin
      mag = MagMax;
    end else if (fcnt_q != '0) begin
      mag = {1'b0, acc_q, quot_q};
    end else begin
      mag = {1'b0, acc_q, {FracBits{1'b0}}};
    end
    value_d = neg_q ? (~mag + 1'b1) : mag;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      value_q <= value_d;
      ovf_q   <= sat_q;
    end
  end

  assign value_o    = value_q;
  assign overflow_o = ovf_q;

  a_sat_holds_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sat_q |-> acc_q == IntLimit)
    else $error("Saturated flag set without the integer limit.");

  a_frac_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fcnt_q <= FracCntW'(MaxFracDigits) && fd_q < pow_ten(fcnt_q))
    else $error("Fraction digits out of range for their count.");

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> rem_q < divisor)
    else $error("Divider remainder reached the divisor.");

  a_reset_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |=> phase_q == PH_SPACE && acc_q == '0 && fcnt_q == '0 && !sat_q)
    else $error("Parse state not cleared after a result was loaded.");

endmodule

`default_nettype wire

// ===== rtl/decimal_text_to_fixed_point.sv =====
// Decimal text to signed fixed-point converter, top level.
// Joins the controller and the datapath; depends on dttfp_pkg,
// dttfp_in_if, dttfp_out_if, dttfp_ctrl and dttfp_dp.
//
// Usage: the text of one number enters on in_i, one character per item,
// with end_of_text set on its last character. After that character one
// item leaves on out_o: value in 32.16 two's complement, truncated toward
// zero, and overflow when the integer part saturated.
// Throughput: one character per cycle while the input is open. After the
// last character the input stays closed through the PREP and LOAD states,
// and through the SCALE state too when kept fraction digits remain and
// the integer part did not saturate; there the bit-serial fraction divider
// makes one quotient bit per cycle. The result is loaded into the output
// register in the LOAD state, when that register is free.
// The output register parts the two sides: the next number's characters
// are accepted while a result waits. When the receiver stalls, the next
// number's last character holds the block until that result is taken.
// Reset clears the parse state and the output valid; the first item can
// be accepted as soon as reset is released.
`default_nettype none

module decimal_text_to_fixed_point (
  input wire          clk_i,
  input wire          rst_ni,
  dttfp_in_if.sink    in_i,
  dttfp_out_if.source out_o
);
  import dttfp_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  dttfp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_last_i   (in_i.end_of_text),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  dttfp_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .char_code_i (in_i.char_code),
    .cmd_i       (cmd),
    .status_o    (status),
    .value_o     (out_o.value),
    .overflow_o  (out_o.overflow)
  );

endmodule

`default_nettype wire
